// ----- hw/rtl/spte_pkg.sv -----
package spte_pkg;

  localparam int unsigned TilePixels = 8;
  localparam int unsigned TileShift  = $clog2(TilePixels);
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned CoordWidth = 14;
  localparam int unsigned PalWidth   = 3;

  // field positions in the size, attribute and load words
  localparam int unsigned SizeColsLsb = 2;
  localparam int unsigned SizeRowsLsb = 0;
  localparam int unsigned AttrPalLsb  = 13;
  localparam int unsigned AttrHflip   = 11;
  localparam int unsigned AttrVflip   = 12;
  localparam int unsigned LoadTileMsb = 11;

  localparam logic [12:0] SharedTileReset = '1;

  // one classified piece, handed from front to back
  typedef struct packed {
    logic [CoordWidth-1:0] xleft;
    logic [CoordWidth-1:0] ytop;
    logic [CoordWidth-1:0] base;
    logic [PalWidth-1:0]   pal;
    logic                  hflip;
    logic                  vflip;
    logic [1:0]            cols_m1;
    logic [1:0]            rows_m1;
  } piece_t;

  // queue side seen by the back end
  typedef struct packed {
    logic   empty;
    piece_t head;
  } q_rd_t;

endpackage

// ----- hw/rtl/sprite_piece_tile_expander.sv -----
// path: piece queue, then descriptor register, then the registered tile outputs
// throughput: one tile per cycle while pop allows; a w x h piece has w*h tiles (1 to 16)
// the back walk over a piece's tiles sets that figure; pieces queue ahead of it
// reset: piece queue and result register empty, palette base 0, shared tile minus one
module sprite_piece_tile_expander #(
  parameter int unsigned QueueDepth = spte_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [11:0]         origin_x_i,
  input  logic [11:0]         origin_y_i,
  input  logic signed [7:0]   piece_y_i,
  input  logic [7:0]          piece_size_i,
  input  logic [15:0]         piece_attr_i,
  input  logic signed [7:0]   piece_x_i,
  input  logic [7:0]          load_count_i,
  input  logic [15:0]         load_word_i,
  input  logic                first_piece_i,
  output logic                empty,
  input  logic                pop,
  output logic signed [13:0]  tile_x_o,
  output logic signed [13:0]  tile_y_o,
  output logic signed [13:0]  tile_number_o,
  output logic [2:0]          palette_line_o,
  output logic                hflip_o,
  output logic                vflip_o,
  output logic                last_tile_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i
);

  spte_pkg::piece_t piece;
  spte_pkg::q_rd_t  q_rd;
  logic             accept, q_pop;

  assign accept = push && !full;

  spte_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .piece_y_i     (piece_y_i),
    .piece_size_i  (piece_size_i),
    .piece_attr_i  (piece_attr_i),
    .piece_x_i     (piece_x_i),
    .load_count_i  (load_count_i),
    .load_word_i   (load_word_i),
    .first_piece_i (first_piece_i),
    .piece_o       (piece)
  );

  spte_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (piece),
    .full_o  (full),
    .rd_i    (q_pop),
    .rd_o    (q_rd)
  );

  spte_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_i            (q_rd),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .tile_x_o       (tile_x_o),
    .tile_y_o       (tile_y_o),
    .tile_number_o  (tile_number_o),
    .palette_line_o (palette_line_o),
    .hflip_o        (hflip_o),
    .vflip_o        (vflip_o),
    .last_tile_o    (last_tile_o)
  );

endmodule

// ----- hw/rtl/spte_front.sv -----
module spte_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_wdata_i,
  input  logic [11:0]           origin_x_i,
  input  logic [11:0]           origin_y_i,
  input  logic signed [7:0]     piece_y_i,
  input  logic [7:0]            piece_size_i,
  input  logic [15:0]           piece_attr_i,
  input  logic signed [7:0]     piece_x_i,
  input  logic [7:0]            load_count_i,
  input  logic [15:0]           load_word_i,
  input  logic                  first_piece_i,
  output spte_pkg::piece_t      piece_o
);

  logic [1:0]  pal_base_q;
  logic [12:0] shared_tile_q, shared_tile_d;
  logic        count_one;
  logic [spte_pkg::CoordWidth-1:0] base;

  assign count_one = (load_count_i == 8'd1);

  always_comb begin
    shared_tile_d = shared_tile_q;
    if (accept_i && first_piece_i && count_one) begin
      shared_tile_d = {1'b0, load_word_i[spte_pkg::LoadTileMsb:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_base_q    <= '0;
      shared_tile_q <= spte_pkg::SharedTileReset;
    end else begin
      if (cfg_we_i) begin
        pal_base_q <= cfg_wdata_i;
      end
      shared_tile_q <= shared_tile_d;
    end
  end

  // the current piece already sees a tile stored by itself
  always_comb begin
    if (load_count_i > 8'd1) begin
      base = {2'b00, load_word_i[spte_pkg::LoadTileMsb:0]};
    end else if (count_one) begin
      base = {shared_tile_d[12], shared_tile_d};
    end else begin
      base = '1;
    end
  end

  always_comb begin
    piece_o.xleft   = {2'b00, origin_x_i} + {{6{piece_x_i[7]}}, piece_x_i};
    piece_o.ytop    = {2'b00, origin_y_i} + {{6{piece_y_i[7]}}, piece_y_i};
    piece_o.base    = base;
    piece_o.pal     = {1'b0, piece_attr_i[spte_pkg::AttrPalLsb +: 2]} + {1'b0, pal_base_q};
    piece_o.hflip   = piece_attr_i[spte_pkg::AttrHflip];
    piece_o.vflip   = piece_attr_i[spte_pkg::AttrVflip];
    piece_o.cols_m1 = piece_size_i[spte_pkg::SizeColsLsb +: 2];
    piece_o.rows_m1 = piece_size_i[spte_pkg::SizeRowsLsb +: 2];
  end

endmodule

// ----- hw/rtl/spte_fifo.sv -----
module spte_fifo #(
  parameter int unsigned Depth = spte_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  spte_pkg::piece_t wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output spte_pkg::q_rd_t  rd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  spte_pkg::piece_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign rd_o.empty = (cnt_q == '0);
  assign rd_o.head  = mem_q[rptr_q];
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && !rd_o.empty;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/spte_back.sv -----
module spte_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spte_pkg::q_rd_t         q_i,
  output logic                    q_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [13:0]      tile_x_o,
  output logic signed [13:0]      tile_y_o,
  output logic signed [13:0]      tile_number_o,
  output logic [2:0]              palette_line_o,
  output logic                    hflip_o,
  output logic                    vflip_o,
  output logic                    last_tile_o
);

  spte_pkg::piece_t desc_q;
  logic       busy_q;
  logic [1:0] col_q, row_q;
  logic [3:0] n_q;
  logic       out_valid_q;
  logic       can_load, emit, last_w;
  logic [1:0] col, row;

  assign can_load = !out_valid_q || pop;
  assign emit     = can_load && busy_q;
  assign last_w   = (col_q == desc_q.cols_m1) && (row_q == desc_q.rows_m1);
  assign q_pop_o  = can_load && !q_i.empty && (!busy_q || last_w);
  assign empty    = !out_valid_q;

  // flips reverse walk order, index keeps rising
  assign col = desc_q.hflip ? desc_q.cols_m1 - col_q : col_q;
  assign row = desc_q.vflip ? desc_q.rows_m1 - row_q : row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        col_q  <= '0;
        row_q  <= '0;
        n_q    <= '0;
      end else if (emit && last_w) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        n_q <= n_q + 1'b1;
        if (row_q == desc_q.rows_m1) begin
          row_q <= '0;
          col_q <= col_q + 1'b1;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      desc_q <= q_i.head;
    end
    if (emit) begin
      tile_x_o       <= desc_q.xleft + (14'(col) << spte_pkg::TileShift);
      tile_y_o       <= desc_q.ytop + (14'(row) << spte_pkg::TileShift);
      tile_number_o  <= desc_q.base + 14'(n_q);
      palette_line_o <= desc_q.pal;
      hflip_o        <= desc_q.hflip;
      vflip_o        <= desc_q.vflip;
      last_tile_o    <= last_w;
    end
  end

  // the next piece is fetched only when the current one is done
  a_pop_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (!busy_q || (emit && last_w)))
    else $error("piece fetched mid-walk");

  // emission index tracks the column-then-row position
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (n_q == ({2'b00, col_q} * ({2'b00, desc_q.rows_m1} + 4'd1)
                        + {2'b00, row_q})))
    else $error("tile index out of step with walk");

  // a walk that is not finished keeps going
  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !(emit && last_w)) |=> busy_q)
    else $error("walk dropped before last tile");

endmodule

// ----- tb/sprite_piece_tile_expander_test.sv -----
module sprite_piece_tile_expander_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [7:0]  piece_y;
    logic [7:0]  size;
    logic [15:0] attr;
    logic [7:0]  piece_x;
    logic [7:0]  count;
    logic [15:0] word;
    logic        first;
  } sprite_piece_t;

  typedef struct packed {
    logic [13:0] tile_x;
    logic [13:0] tile_y;
    logic [13:0] tile_number;
    logic [2:0]  line;
    logic        hflip;
    logic        vflip;
    logic        last;
  } tile_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [11:0]        origin_x_i = '0;
  logic [11:0]        origin_y_i = '0;
  logic signed [7:0]  piece_y_i = '0;
  logic [7:0]         piece_size_i = '0;
  logic [15:0]        piece_attr_i = '0;
  logic signed [7:0]  piece_x_i = '0;
  logic [7:0]         load_count_i = '0;
  logic [15:0]        load_word_i = '0;
  logic               first_piece_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [13:0] tile_x_o;
  logic signed [13:0] tile_y_o;
  logic signed [13:0] tile_number_o;
  logic [2:0]         palette_line_o;
  logic               hflip_o;
  logic               vflip_o;
  logic               last_tile_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_wdata_i = '0;

  // predictor state
  logic [1:0]   palette_base_now = '0;
  logic [12:0]  shared_base = spte_pkg::SharedTileReset;
  tile_beat_t   pending_tiles[$];

  int unsigned  fault_count = 0;
  bit           send_steady = 1'b0;
  bit           sink_steady = 1'b0;
  int unsigned  sink_hold = 0;

  sprite_piece_tile_expander dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .piece_y_i      (piece_y_i),
    .piece_size_i   (piece_size_i),
    .piece_attr_i   (piece_attr_i),
    .piece_x_i      (piece_x_i),
    .load_count_i   (load_count_i),
    .load_word_i    (load_word_i),
    .first_piece_i  (first_piece_i),
    .empty          (empty),
    .pop            (pop),
    .tile_x_o       (tile_x_o),
    .tile_y_o       (tile_y_o),
    .tile_number_o  (tile_number_o),
    .palette_line_o (palette_line_o),
    .hflip_o        (hflip_o),
    .vflip_o        (vflip_o),
    .last_tile_o    (last_tile_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_fault(input string msg);
    $display("tile check: %s", msg);
    fault_count++;
  endtask

  task automatic check_field(input string name, input logic [13:0] seen, input logic [13:0] want);
    if (seen !== want) begin
      report_fault($sformatf("%s got %0h want %0h", name, seen, want));
    end
  endtask

  // expands one accepted piece into its tile beats, column by column
  function automatic void expand_piece(input sprite_piece_t pc);
    logic [13:0] xleft, ytop, base;
    logic [2:0]  line;
    logic        hf, vf;
    int unsigned cols, rows, n, c, r, col, row;
    tile_beat_t  t;
    cols = int'(pc.size[spte_pkg::SizeColsLsb +: 2]) + 1;
    rows = int'(pc.size[spte_pkg::SizeRowsLsb +: 2]) + 1;
    hf = pc.attr[spte_pkg::AttrHflip];
    vf = pc.attr[spte_pkg::AttrVflip];
    line = 3'(pc.attr[spte_pkg::AttrPalLsb +: 2]) + 3'(palette_base_now);
    xleft = 14'(pc.origin_x) + 14'(signed'(pc.piece_x));
    ytop = 14'(pc.origin_y) + 14'(signed'(pc.piece_y));
    if (pc.first && pc.count == 8'd1) begin
      shared_base = 13'(pc.word[spte_pkg::LoadTileMsb:0]);
    end
    if (pc.count > 8'd1) begin
      base = 14'(pc.word[spte_pkg::LoadTileMsb:0]);
    end else if (pc.count == 8'd1) begin
      base = 14'(signed'(shared_base));
    end else begin
      base = '1;
    end
    n = 0;
    for (c = 0; c < cols; c++) begin
      col = hf ? cols - 1 - c : c;
      for (r = 0; r < rows; r++) begin
        row = vf ? rows - 1 - r : r;
        t.tile_x = xleft + 14'(col * spte_pkg::TilePixels);
        t.tile_y = ytop + 14'(row * spte_pkg::TilePixels);
        t.tile_number = base + 14'(n);
        t.line = line;
        t.hflip = hf;
        t.vflip = vf;
        t.last = (n + 1 == cols * rows);
        pending_tiles.push_back(t);
        n++;
      end
    end
  endfunction

  function automatic sprite_piece_t make_piece(
    input logic [11:0] ox, input logic [11:0] oy, input logic [7:0] py,
    input logic [7:0] px, input logic [7:0] size, input logic [15:0] attr,
    input logic [7:0] count, input logic [15:0] word, input logic first
  );
    sprite_piece_t pc;
    pc.origin_x = ox;
    pc.origin_y = oy;
    pc.piece_y = py;
    pc.piece_x = px;
    pc.size = size;
    pc.attr = attr;
    pc.count = count;
    pc.word = word;
    pc.first = first;
    return pc;
  endfunction

  function automatic sprite_piece_t random_piece();
    return make_piece(12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                      1'($urandom));
  endfunction

  // push stays high after the beat so back-to-back pieces follow without push dropping
  task automatic send_piece(input sprite_piece_t pc);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    origin_x_i <= pc.origin_x;
    origin_y_i <= pc.origin_y;
    piece_y_i <= pc.piece_y;
    piece_size_i <= pc.size;
    piece_attr_i <= pc.attr;
    piece_x_i <= pc.piece_x;
    load_count_i <= pc.count;
    load_word_i <= pc.word;
    first_piece_i <= pc.first;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    expand_piece(pc);
  endtask

  task automatic wait_tiles_drained();
    push <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_palette_base(input logic [1:0] value);
    wait_tiles_drained();
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    palette_base_now = value;
  endtask

  task automatic test_shared_tile_reset();
    // single load entry but no store yet, so numbering starts at minus one
    send_piece(make_piece(12'd100, 12'd200, 8'h08, 8'hF8, 8'h0F, 16'h0000, 8'd1, 16'h0123, 1'b0));
    send_piece(make_piece(12'd50, 12'd60, 8'h00, 8'h00, 8'h05, 16'h0000, 8'd0, 16'h0ABC, 1'b1));
  endtask

  task automatic test_field_extremes();
    send_piece(make_piece(12'd0, 12'd0, 8'h80, 8'h80, 8'h00, 16'h0000, 8'd2, 16'h0000, 1'b0));
    send_piece(make_piece(12'hFFF, 12'hFFF, 8'h7F, 8'h7F, 8'hFF, 16'hFFFF, 8'd255, 16'hFFFF,
                          1'b1));
    // unused size and attribute bits set, no flips
    send_piece(make_piece(12'd7, 12'd9, 8'hFF, 8'h01, 8'hF0, 16'h87FF, 8'd3, 16'hF123, 1'b0));
  endtask

  task automatic test_flips();
    logic [15:0] flip;
    for (int k = 0; k < 4; k++) begin
      flip = '0;
      flip[spte_pkg::AttrHflip] = k[0];
      flip[spte_pkg::AttrVflip] = k[1];
      send_piece(make_piece(12'd300, 12'd400, 8'hF0, 8'h10, 8'h0E, flip, 8'd4, 16'h0200, 1'b1));
    end
  endtask

  task automatic test_load_counts();
    send_piece(make_piece(12'd10, 12'd10, 8'h00, 8'h00, 8'h01, 16'h0000, 8'd1, 16'h0ABC, 1'b1));
    send_piece(make_piece(12'd10, 12'd10, 8'h08, 8'h00, 8'h04, 16'h0000, 8'd1, 16'h0555, 1'b0));
    // count of zero leaves the held tile alone
    send_piece(make_piece(12'd10, 12'd10, 8'h10, 8'h00, 8'h00, 16'h0000, 8'd0, 16'h0777, 1'b1));
    send_piece(make_piece(12'd10, 12'd10, 8'h18, 8'h00, 8'h00, 16'h0000, 8'd1, 16'h0999, 1'b0));
    // differing counts within one sprite
    send_piece(make_piece(12'd10, 12'd10, 8'h20, 8'h00, 8'h03, 16'h0000, 8'd5, 16'h0123, 1'b0));
    send_piece(make_piece(12'd20, 12'd20, 8'h00, 8'h00, 8'h0F, 16'h0000, 8'd1, 16'hFFFF, 1'b1));
    send_piece(make_piece(12'd20, 12'd20, 8'h00, 8'h20, 8'h02, 16'h0000, 8'd1, 16'h0001, 1'b0));
  endtask

  task automatic test_palette_lines();
    logic [1:0] settings[4] = '{2'd3, 2'd1, 2'd2, 2'd0};
    foreach (settings[i]) begin
      set_palette_base(settings[i]);
      send_piece(make_piece(12'd5, 12'd5, 8'h00, 8'h00, 8'h00, 16'h6000, 8'd2, 16'h0040, 1'b0));
      send_piece(make_piece(12'd5, 12'd5, 8'h00, 8'h00, 8'h01, 16'h2000, 8'd2, 16'h0041, 1'b0));
    end
  endtask

  task automatic test_backpressure();
    wait_tiles_drained();
    send_steady = 1'b1;
    sink_hold = 300;
    for (int k = 0; k < 16; k++) begin
      send_piece(make_piece(12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom), 8'h0F,
                            16'($urandom), 8'd2, 16'($urandom), 1'b0));
    end
    send_steady = 1'b0;
    wait_tiles_drained();
  endtask

  task automatic test_random_sprites(input int unsigned n_items);
    int unsigned   sent, pieces, next_cfg;
    logic [7:0]    count;
    logic [15:0]   word;
    logic [11:0]   ox, oy;
    sprite_piece_t pc;
    sent = 0;
    next_cfg = 80;
    while (sent < n_items) begin
      if (sent >= next_cfg) begin
        set_palette_base(2'($urandom));
        next_cfg += 80;
      end
      send_steady = ($urandom_range(0, 5) == 0);
      sink_steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_piece(random_piece());
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0: count = 8'd0;
          1: count = 8'd1;
          default: count = 8'($urandom_range(2, 255));
        endcase
        word = 16'($urandom);
        ox = 12'($urandom);
        oy = 12'($urandom);
        pieces = $urandom_range(1, 6);
        for (int k = 0; k < pieces; k++) begin
          pc = random_piece();
          pc.origin_x = ox;
          pc.origin_y = oy;
          pc.first = (k == 0);
          if ($urandom_range(0, 11) != 0) pc.count = count;
          if ($urandom_range(0, 1) == 0) pc.word = word;
          send_piece(pc);
          sent++;
        end
      end
    end
    send_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin : tile_sink
    int unsigned idle_left;
    tile_beat_t  seen, want;
    idle_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        seen = '{tile_x_o, tile_y_o, tile_number_o, palette_line_o, hflip_o, vflip_o,
                 last_tile_o};
        if (pending_tiles.size() == 0) begin
          report_fault("tile beat with nothing expected");
        end else begin
          want = pending_tiles.pop_front();
          check_field("tile_x", seen.tile_x, want.tile_x);
          check_field("tile_y", seen.tile_y, want.tile_y);
          check_field("tile_number", seen.tile_number, want.tile_number);
          check_field("palette_line", 14'(seen.line), 14'(want.line));
          check_field("hflip", 14'(seen.hflip), 14'(want.hflip));
          check_field("vflip", 14'(seen.vflip), 14'(want.vflip));
          check_field("last_tile", 14'(seen.last), 14'(want.last));
        end
        idle_left = sink_steady ? 0 : $urandom_range(0, 13);
      end
      // a long hold lets the piece queue fill and stall the input side
      if (sink_hold > 0) begin
        sink_hold = sink_hold - 1;
        pop <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left = idle_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_shared_tile_reset();
    test_field_extremes();
    test_flips();
    test_load_counts();
    test_palette_lines();
    test_backpressure();
    test_random_sprites(320);
    wait_tiles_drained();
    repeat (30) @(posedge clk_i);
    if (pending_tiles.size() != 0) begin
      report_fault($sformatf("%0d tile beats never arrived", pending_tiles.size()));
    end
    if (fault_count == 0) begin
      $display("sprite_piece_tile_expander_test: clean");
    end else begin
      $display("sprite_piece_tile_expander_test: errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("sprite_piece_tile_expander_test: errors");
    $finish;
  end

endmodule
